FILE: hdl/dsd_pkg.sv
`timescale 1ns / 1ps
package dsd_pkg;

    localparam int DEF_MAX_ROWS = 64;
    localparam int ROWS_W       = 7;
    localparam int CODE_LEN     = 6;
    localparam int COL_W        = 3;
    localparam int DATA_W       = 3;
    localparam int TDATA_OUT_W  = 8;
    localparam int TDATA_IN_W   = 8;
    localparam int TUSER_W      = 2;

    localparam logic [ROWS_W-1:0]   RESET_ROWS = 7'd8;
    localparam logic [COL_W-1:0]    LAST_COL   = 3'd5;

    // parity check masks over the 6 code bits
    localparam logic [CODE_LEN-1:0] CHECK0_MASK = 6'h07;
    localparam logic [CODE_LEN-1:0] CHECK1_MASK = 6'h19;
    localparam logic [CODE_LEN-1:0] CHECK2_MASK = 6'h2A;

    localparam logic [2:0] SYN_CLEAN = 3'd7;
    localparam logic [2:0] SYN_FAIL  = 3'd0;

    // tuser bit positions on the result side
    localparam int USER_CORR_BIT = 0;
    localparam int USER_UNC_BIT  = 1;

    typedef struct packed {
        logic [DATA_W-1:0] data;
        logic              corrected;
        logic              uncorrectable;
    } t_dec;

    function automatic t_dec decode(input logic [CODE_LEN-1:0] word);
        logic [2:0]          syn;
        logic [CODE_LEN-1:0] fixed;
        t_dec                res;
        syn = {~(^(word & CHECK0_MASK)), ~(^(word & CHECK1_MASK)), ~(^(word & CHECK2_MASK))};
        fixed = word;
        res.corrected     = 1'b0;
        res.uncorrectable = 1'b0;
        case (syn)
            SYN_CLEAN: ;
            SYN_FAIL:  res.uncorrectable = 1'b1;
            default: begin
                fixed = word ^ (CODE_LEN'(1) << (syn - 3'd1));
                res.corrected = 1'b1;
            end
        endcase
        res.data = {fixed[3], fixed[1], fixed[0]};
        return res;
    endfunction

endpackage

FILE: hdl/dsd_ram.sv
`timescale 1ns / 1ps
// simple dual-port RAM, one write port, one registered read port
module dsd_ram #(
    parameter int WIDTH  = 6,
    parameter int DEPTH  = 64,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              i_clk,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]  i_wr_data,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [WIDTH-1:0]  o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

FILE: hdl/deinterleave_syndrome_decoder_unit.sv
`timescale 1ns / 1ps
// Block deinterleaver with a (6,3) syndrome decoder. Received bits come in one
// per input word (i_s_tdata[0]) and fill a block of `rows` six-bit code words
// column-major: column 0 goes to rows 0..rows-1, then column 1, up to column 5.
// The bit that completes a block starts a drain that sends one decoded word per
// row, in row order, with tlast on the final row. Each row's 3-bit syndrome
// (inverted check bits) picks the action: 7 = clean, 1..6 = flip code bit
// (value - 1) and flag corrected, 0 = flag uncorrectable, pass unchanged. Data
// out is code bits {3,1,0}. The rows register (reset 8; 0 acts as 1, above
// MAX_ROWS acts as MAX_ROWS) is written over the cfg channel while idle and
// restarts the block. The block store sits in one RAM with a registered read,
// and every input bit is a read-modify-write of its row, so a new input word is
// taken only after the previous bit is written back. The drain reads the first
// row, then holds each output word until the sink takes it and reads the next
// row as that word is taken; no input is taken during the drain.
module deinterleave_syndrome_decoder_unit #(
    parameter int MAX_ROWS = dsd_pkg::DEF_MAX_ROWS
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // cfg write channel: rows register
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [6:0] i_cfg_data,   // [6:0] rows
    // input stream
    input  logic       i_s_tvalid,
    output logic       o_s_tready,
    input  logic [7:0] i_s_tdata,    // [0] channel_bit, [7:1] zero
    // output stream
    output logic       o_m_tvalid,
    input  logic       i_m_tready,
    output logic [7:0] o_m_tdata,    // [2:0] data_word, [7:3] zero
    output logic [1:0] o_m_tuser,    // [0] corrected, [1] uncorrectable
    output logic       o_m_tlast     // last word of block
);

    localparam int ROW_W    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
    localparam int CODE_LEN = dsd_pkg::CODE_LEN;
    localparam int COL_W    = dsd_pkg::COL_W;

    // sequencer codes
    localparam logic [2:0] S_IDLE       = 3'd0;  // take cfg or an input word
    localparam logic [2:0] S_WRITE      = 3'd1;  // merge bit into row, write back
    localparam logic [2:0] S_DRAIN_RD   = 3'd2;  // first drain read
    localparam logic [2:0] S_DRAIN_OUT  = 3'd3;  // decode read data into out regs
    localparam logic [2:0] S_DRAIN_WAIT = 3'd4;  // hold result until taken

    logic [2:0]                  r_state, n_state;
    logic [dsd_pkg::ROWS_W-1:0]  r_rows, n_rows;
    logic [ROW_W-1:0]            r_row, n_row;
    logic [COL_W-1:0]            r_col, n_col;
    logic                        r_bit, n_bit;
    logic [ROW_W-1:0]            r_drain_row, n_drain_row;
    logic                        r_out_valid, n_out_valid;
    logic [dsd_pkg::DATA_W-1:0]  r_out_data, n_out_data;
    logic                        r_out_corr, n_out_corr;
    logic                        r_out_unc, n_out_unc;
    logic                        r_out_last, n_out_last;

    logic [ROW_W-1:0]    last_row;
    logic                cfg_acc, in_acc, out_acc;
    logic                ram_wr_en, ram_rd_en;
    logic [ROW_W-1:0]    ram_rd_addr;
    logic [CODE_LEN-1:0] ram_rd_data, merged;
    dsd_pkg::t_dec       dec;

    // effective depth minus one: 0 acts as 1, oversize clamps to MAX_ROWS
    always_comb begin
        if (r_rows == '0) begin
            last_row = '0;
        end else if (int'(r_rows) > MAX_ROWS) begin
            last_row = ROW_W'(MAX_ROWS - 1);
        end else begin
            last_row = ROW_W'(r_rows - 7'd1);
        end
    end

    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_s_tready  = (r_state == S_IDLE) && !i_cfg_valid;
    assign cfg_acc     = i_cfg_valid && o_cfg_ready;
    assign in_acc      = i_s_tvalid && o_s_tready;
    assign out_acc     = r_out_valid && i_m_tready;

    always_comb begin
        merged        = ram_rd_data;
        merged[r_col] = r_bit;
    end

    assign dec = dsd_pkg::decode(ram_rd_data);

    always_comb begin
        n_state     = r_state;
        n_rows      = r_rows;
        n_row       = r_row;
        n_col       = r_col;
        n_bit       = r_bit;
        n_drain_row = r_drain_row;
        n_out_valid = r_out_valid;
        n_out_data  = r_out_data;
        n_out_corr  = r_out_corr;
        n_out_unc   = r_out_unc;
        n_out_last  = r_out_last;
        ram_wr_en   = 1'b0;
        ram_rd_en   = 1'b0;
        ram_rd_addr = r_row;
        unique case (r_state)
            S_IDLE: begin
                if (cfg_acc) begin
                    n_rows = i_cfg_data;
                    n_row  = '0;
                    n_col  = '0;
                end else if (in_acc) begin
                    n_bit     = i_s_tdata[0];
                    ram_rd_en = 1'b1;
                    n_state   = S_WRITE;
                end
            end
            S_WRITE: begin
                ram_wr_en = 1'b1;
                n_state   = S_IDLE;
                if (r_row == last_row) begin
                    n_row = '0;
                    if (r_col == dsd_pkg::LAST_COL) begin
                        n_col       = '0;
                        n_drain_row = '0;
                        n_state     = S_DRAIN_RD;
                    end else begin
                        n_col = r_col + 3'd1;
                    end
                end else begin
                    n_row = r_row + 1'b1;
                end
            end
            S_DRAIN_RD: begin
                ram_rd_en   = 1'b1;
                ram_rd_addr = r_drain_row;
                n_state     = S_DRAIN_OUT;
            end
            S_DRAIN_OUT: begin
                n_out_valid = 1'b1;
                n_out_data  = dec.data;
                n_out_corr  = dec.corrected;
                n_out_unc   = dec.uncorrectable;
                n_out_last  = (r_drain_row == last_row);
                n_state     = S_DRAIN_WAIT;
            end
            S_DRAIN_WAIT: begin
                if (out_acc) begin
                    n_out_valid = 1'b0;
                    if (r_out_last) begin
                        n_state = S_IDLE;
                    end else begin
                        // fetch next row while the slot empties
                        n_drain_row = r_drain_row + 1'b1;
                        ram_rd_en   = 1'b1;
                        ram_rd_addr = r_drain_row + 1'b1;
                        n_state     = S_DRAIN_OUT;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_rows      <= dsd_pkg::RESET_ROWS;
            r_row       <= '0;
            r_col       <= '0;
            r_drain_row <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_rows      <= n_rows;
            r_row       <= n_row;
            r_col       <= n_col;
            r_drain_row <= n_drain_row;
            r_out_valid <= n_out_valid;
        end
    end

    // payload, no reset
    always_ff @(posedge i_clk) begin
        r_bit      <= n_bit;
        r_out_data <= n_out_data;
        r_out_corr <= n_out_corr;
        r_out_unc  <= n_out_unc;
        r_out_last <= n_out_last;
    end

    dsd_ram #(
        .WIDTH  (CODE_LEN),
        .DEPTH  (MAX_ROWS),
        .ADDR_W (ROW_W)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_row),
        .i_wr_data (merged),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (ram_rd_data)
    );

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {5'd0, r_out_data};
    assign o_m_tuser  = {r_out_unc, r_out_corr};
    assign o_m_tlast  = r_out_last;

endmodule

FILE: hdl/dsd_checker.sv
`timescale 1ns / 1ps
module dsd_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_cfg_valid,
    input logic       o_cfg_ready,
    input logic [6:0] i_cfg_data,
    input logic       i_s_tvalid,
    input logic       o_s_tready,
    input logic [7:0] i_s_tdata,
    input logic       o_m_tvalid,
    input logic       i_m_tready,
    input logic [7:0] o_m_tdata,
    input logic [1:0] o_m_tuser,
    input logic       o_m_tlast
);

    // a result word holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata)
            && $stable(o_m_tuser) && $stable(o_m_tlast))
        else $error("result word changed while stalled");

    // no input word is taken while a drain word is pending
    a_no_in_during_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !o_s_tready)
        else $error("input taken during drain");

    // corrected and uncorrectable never together
    a_flags_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid |-> !(o_m_tuser[dsd_pkg::USER_CORR_BIT] && o_m_tuser[dsd_pkg::USER_UNC_BIT]))
        else $error("both corrected and uncorrectable set");

    // a cfg write and an input word never land on the same edge
    a_cfg_in_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid && o_cfg_ready |-> !(i_s_tvalid && o_s_tready))
        else $error("cfg write and input word on same edge");

    // nothing comes out right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("output valid after reset");

endmodule

bind deinterleave_syndrome_decoder_unit dsd_checker u_dsd_checker (.*);
